// ----- rtl/core/bfs_shortest_path_graph_macros.svh -----
// Assertion helpers for the shortest-path engine
`ifndef BFS_SHORTEST_PATH_GRAPH_MACROS_SVH
`define BFS_SHORTEST_PATH_GRAPH_MACROS_SVH

`define BSP_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define BSP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/bsp_pkg.sv -----
`default_nettype none
package bsp_pkg;

  localparam int MaxVertices = 64;

  typedef enum logic [1:0] {
    OP_ADD_VERTEX = 2'd0,
    OP_ADD_EDGE   = 2'd1,
    OP_DEL_EDGE   = 2'd2,
    OP_QUERY      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_RANGE       = 2'd1,
    ST_FULL        = 2'd2,
    ST_UNREACHABLE = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0] op;
    logic [5:0] vertex_a;
    logic [5:0] vertex_b;
  } cmd_t;

  typedef struct packed {
    logic [5:0]  path_vertex;
    logic        last;
    logic [1:0]  status;
    logic [6:0]  vertex_count;
    logic [11:0] edge_count;
  } result_t;

  // classified command passed front to back
  typedef struct packed {
    op_t        op;
    logic       bad;
    logic [5:0] a;
    logic [5:0] b;
  } job_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EDIT_RD,
    S_EDIT_WR,
    S_CLEAR,
    S_DEQ,
    S_ROW,
    S_SCAN,
    S_TRACE,
    S_TRACE_RD,
    S_EMIT_RD,
    S_EMIT
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/core/bsp_front.sv -----
`default_nettype none
module bsp_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire bsp_pkg::cmd_t cmd,
  output logic               busy,
  output logic               q_valid,
  output bsp_pkg::job_t      q_job,
  input  wire logic          q_pop,
  input  wire logic          back_idle,
  input  wire logic [6:0]    vcount
);
  import bsp_pkg::*;

  // two-entry queue; vertex count is read at issue time so adds are ordered
  job_t       slot [2];
  logic [1:0] fill;
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] fill_next;
  logic       push;
  logic       outstanding;
  job_t       job_in;

  // the range check needs the count left by earlier items, so issue only
  // when nothing is queued or running
  assign outstanding = (fill != 2'd0) || !back_idle;
  assign busy        = outstanding;
  assign push        = start && !busy;

  always_comb begin
    job_in.op  = op_t'(cmd.op);
    job_in.a   = cmd.vertex_a;
    job_in.b   = cmd.vertex_b;
    job_in.bad = (cmd.op != OP_ADD_VERTEX) &&
                 (({1'b0, cmd.vertex_a} >= vcount) || ({1'b0, cmd.vertex_b} >= vcount));
  end

  always_comb begin
    fill_next = fill;
    if (push && !q_pop) fill_next = fill + 2'd1;
    if (!push && q_pop) fill_next = fill - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      fill <= fill_next;
      if (push) wr_ptr <= !wr_ptr;
      if (q_pop) rd_ptr <= !rd_ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= job_in;
  end

  assign q_valid = (fill != 2'd0);
  assign q_job   = slot[rd_ptr];
endmodule
`default_nettype wire

// ----- rtl/core/bsp_back.sv -----
`default_nettype none
module bsp_back #(
  parameter int MAX_VERTICES = bsp_pkg::MaxVertices
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire bsp_pkg::job_t q_job,
  output logic               q_pop,
  output logic               idle,
  output logic [6:0]         vcount,
  output logic               done,
  output bsp_pkg::result_t   res
);
  import bsp_pkg::*;

  logic [63:0] adj [64];
  logic [63:0] row_rd;
  logic [5:0]  row_addr;
  logic        row_we;
  logic [5:0]  row_waddr;
  logic [63:0] row_wdata;

  // adjacency rows hold no reset: rows must read zero after reset, so a
  // row-valid mask stands in for never-written rows
  logic [63:0] row_valid;
  logic [63:0] row_eff;

  logic [6:0]  pred [64];
  logic [5:0]  fq   [64];
  logic [5:0]  ps   [64];

  state_t      state, state_next;
  job_t        job;
  logic [63:0] visited;
  logic [63:0] cand;
  logic [6:0]  head, tail;
  logic [5:0]  cur;
  logic [6:0]  depth;
  logic [6:0]  vcnt;
  logic [12:0] entries;
  logic        second;
  logic [6:0]  clr;
  logic [1:0]  st_q;
  logic [5:0]  fq_rd, ps_rd;
  logic [6:0]  pred_rd;
  logic [5:0]  pred_addr;
  logic        done_next;

  logic [5:0]  nb;
  logic        nb_any;
  logic [5:0]  col;
  logic [63:0] bitmask;
  logic        have;
  logic [63:0] row_new;

  // priority encoder over unvisited neighbors
  always_comb begin
    nb     = '0;
    nb_any = 1'b0;
    for (int i = 63; i >= 0; i--) begin
      if (cand[i]) begin
        nb     = 6'(i);
        nb_any = 1'b1;
      end
    end
  end

  assign col     = second ? job.a : job.b;
  assign bitmask = 64'd1 << col;
  assign row_eff = row_valid[row_addr] ? row_rd : '0;
  assign have    = (row_eff & bitmask) != '0;
  assign row_new = (job.op == OP_ADD_EDGE) ? (row_eff | bitmask) : (row_eff & ~bitmask);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          if (q_job.op == OP_QUERY && !q_job.bad) state_next = S_CLEAR;
          else if ((q_job.op == OP_ADD_EDGE || q_job.op == OP_DEL_EDGE) && !q_job.bad)
            state_next = S_EDIT_RD;
          else state_next = S_IDLE;
        end
      end
      S_EDIT_RD: state_next = S_EDIT_WR;
      S_EDIT_WR: state_next = second ? S_IDLE : S_EDIT_RD;
      S_CLEAR:   state_next = (clr == 7'd63) ? S_DEQ : S_CLEAR;
      S_DEQ:     state_next = (head < tail) ? S_ROW : S_TRACE;
      S_ROW:     state_next = S_SCAN;
      S_SCAN:    state_next = nb_any ? S_SCAN : S_DEQ;
      S_TRACE:   state_next = S_TRACE_RD;
      S_TRACE_RD: state_next = (pred_rd[6] || depth == 7'd64) ? S_EMIT_RD : S_TRACE_RD;
      S_EMIT_RD: state_next = S_EMIT;
      S_EMIT:    state_next = (depth == 7'd1) ? S_IDLE : S_EMIT_RD;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    row_addr  = second ? job.b : job.a;
    row_we    = 1'b0;
    row_waddr = row_addr;
    row_wdata = row_new;
    q_pop     = 1'b0;
    unique case (state)
      S_IDLE:    begin q_pop = q_valid; row_addr = q_job.a; end
      S_EDIT_WR: row_we = 1'b1;
      S_DEQ:     row_addr = fq_rd;
      S_ROW:     row_addr = cur;
      S_SCAN:    row_addr = cur;
      default:   ;
    endcase
  end

  // predecessor read address runs one hop ahead during the trace
  always_comb begin
    unique case (state)
      S_TRACE:    pred_addr = job.b;
      S_TRACE_RD: pred_addr = pred_rd[5:0];
      default:    pred_addr = cur;
    endcase
  end

  always_comb begin
    done_next = ((state == S_IDLE) && q_valid && (q_job.op == OP_ADD_VERTEX || q_job.bad)) ||
                ((state == S_EDIT_WR) && second) ||
                (state == S_EMIT);
  end

  always_ff @(posedge clk) begin
    if (row_we) adj[row_waddr] <= row_wdata;
    row_rd <= adj[row_addr];
  end

  // scratch memories, registered reads
  always_ff @(posedge clk) begin
    fq_rd   <= fq[head[5:0]];
    ps_rd   <= ps[depth[5:0] - 6'd1];
    pred_rd <= pred[pred_addr];
    if (state == S_CLEAR) pred[clr[5:0]] <= 7'd64;
    if (state == S_SCAN && nb_any) pred[nb] <= {1'b0, cur};
    if (state == S_SCAN && nb_any && !tail[6]) fq[tail[5:0]] <= nb;
    if (state == S_CLEAR && clr == 7'd0) fq[0] <= job.a;
    if (state == S_TRACE) ps[0] <= job.b;
    if (state == S_TRACE_RD && !pred_rd[6] && depth != 7'd64)
      ps[depth[5:0]] <= pred_rd[5:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      vcnt      <= '0;
      entries   <= '0;
      done      <= 1'b0;
      second    <= 1'b0;
      row_valid <= '0;
    end else begin
      state <= state_next;
      done  <= done_next;
      unique case (state)
        S_IDLE: if (q_valid) begin
          job    <= q_job;
          second <= 1'b0;
          clr    <= '0;
          head   <= '0;
          tail   <= 7'd1;
          depth  <= 7'd1;
          res.path_vertex <= '0;
          res.last        <= 1'b1;
          if (q_job.op == OP_ADD_VERTEX) begin
            if (vcnt >= 7'(MAX_VERTICES)) res.status <= ST_FULL;
            else begin
              res.status <= ST_OK;
              vcnt       <= vcnt + 7'd1;
            end
            res.vertex_count <= (vcnt >= 7'(MAX_VERTICES)) ? vcnt : vcnt + 7'd1;
            res.edge_count   <= entries[12:1];
          end else if (q_job.bad) begin
            res.status       <= ST_RANGE;
            res.vertex_count <= vcnt;
            res.edge_count   <= entries[12:1];
          end
        end
        S_EDIT_WR: begin
          row_valid[row_waddr] <= 1'b1;
          second <= 1'b1;
          if (job.op == OP_ADD_EDGE && !(have && row_valid[row_waddr]))
            entries <= entries + 13'd1;
          if (job.op == OP_DEL_EDGE && have && row_valid[row_waddr])
            entries <= entries - 13'd1;
          if (second) begin
            res.path_vertex  <= '0;
            res.last         <= 1'b1;
            res.status       <= ST_OK;
            res.vertex_count <= vcnt;
            res.edge_count   <= (job.op == OP_ADD_EDGE && !(have && row_valid[row_waddr]))
                                ? 12'((entries + 13'd1) >> 1)
                                : (job.op == OP_DEL_EDGE && have && row_valid[row_waddr])
                                ? 12'((entries - 13'd1) >> 1) : entries[12:1];
          end
        end
        S_CLEAR: begin
          clr     <= clr + 7'd1;
          visited <= 64'd1 << job.a;
        end
        S_DEQ: if (head < tail) begin
          cur  <= fq_rd;
          head <= head + 7'd1;
        end
        S_ROW: ;
        S_SCAN: if (nb_any) begin
          visited[nb] <= 1'b1;
          if (!tail[6]) tail <= tail + 7'd1;
        end
        S_TRACE: cur <= job.b;
        S_TRACE_RD: if (!(pred_rd[6] || depth == 7'd64)) begin
          cur   <= pred_rd[5:0];
          depth <= depth + 7'd1;
        end else begin
          // only the target itself lacking a predecessor means unreachable
          st_q <= (job.a != job.b && depth == 7'd1 && pred_rd[6]) ? ST_UNREACHABLE : ST_OK;
        end
        S_EMIT_RD: ;
        S_EMIT: begin
          depth            <= depth - 7'd1;
          res.path_vertex  <= ps_rd;
          res.last         <= (depth == 7'd1);
          res.status       <= st_q;
          res.vertex_count <= vcnt;
          res.edge_count   <= entries[12:1];
        end
        default: ;
      endcase
    end
  end

  // candidates: current row minus visited; row data arrives the cycle after S_ROW
  always_comb begin
    cand = (row_valid[cur] ? row_rd : '0) & ~visited;
  end

  assign idle   = (state == S_IDLE);
  assign vcount = vcnt;
endmodule
`default_nettype wire

// ----- rtl/core/bfs_shortest_path_graph.sv -----
// Shortest-path engine over an undirected graph held as an adjacency bit matrix.
// Edits: read and rewrite row a, then row b; range errors and vertex adds answer
// from idle. Query: clear all 64 predecessors, then a breadth-first search that
// scans each dequeued row for unvisited neighbors, a trace back along predecessors
// and one result per path vertex. One transaction at a time; busy drops with the
// last result. Sync reset clears counts and marks all adjacency rows empty.
`default_nettype none
`include "bfs_shortest_path_graph_macros.svh"
module bfs_shortest_path_graph #(
  parameter int MAX_VERTICES = bsp_pkg::MaxVertices
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire bsp_pkg::cmd_t    cmd,
  output logic                  busy,
  output logic                  done,
  output bsp_pkg::result_t      result
);
  import bsp_pkg::*;

  logic       q_valid;
  job_t       q_job;
  logic       q_pop;
  logic       back_idle;
  logic [6:0] vcount;

  bsp_front u_front (
    .clk, .rst, .start, .cmd, .busy,
    .q_valid, .q_job, .q_pop, .back_idle, .vcount
  );

  bsp_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
    .clk, .rst, .q_valid, .q_job, .q_pop,
    .idle(back_idle), .vcount, .done, .res(result)
  );

  `BSP_ASSERT_IMPL(a_no_accept_busy, clk, rst, start && busy, !q_pop || q_valid)
  `BSP_ASSERT_IMPL(a_vcount_max, clk, rst, 1'b1, vcount <= 7'(MAX_VERTICES))
  `BSP_ASSERT_IMPL(a_pop_busy, clk, rst, q_pop, busy)
  `BSP_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`default_nettype none
module tb_top;
  import bsp_pkg::*;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  cmd_t    cmd = '0;
  logic    busy;
  logic    done;
  result_t result;

  bfs_shortest_path_graph u_top (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd),
    .busy(busy), .done(done), .result(result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // graph mirror used to predict results
  logic [63:0] adj_rows [64];
  int unsigned nverts;
  int unsigned nentries;

  cmd_t    cmd_q [$];
  result_t path_q [$];
  int      errors;
  int      cycles;
  bit      hold_until_drained;
  int      gap_left;
  int      burst_left;

  function automatic result_t mk_res(logic [5:0] v, logic lst, status_t st);
    result_t r;
    r.path_vertex  = v;
    r.last         = lst;
    r.status       = st;
    r.vertex_count = 7'(nverts);
    r.edge_count   = 12'(nentries >> 1);
    return r;
  endfunction

  task automatic queue_expect(result_t r);
    path_q.insert(path_q.size(), r);
  endtask

  task automatic queue_cmd(cmd_t c);
    cmd_q.insert(cmd_q.size(), c);
  endtask

  task automatic set_bit(int r, int c);
    if (!adj_rows[r][c]) begin
      adj_rows[r][c] = 1'b1;
      nentries++;
    end
  endtask

  task automatic clr_bit(int r, int c);
    if (adj_rows[r][c]) begin
      adj_rows[r][c] = 1'b0;
      nentries--;
    end
  endtask

  // BFS with ascending neighbor scan; queues expected path transactions
  task automatic predict_cmd(cmd_t c);
    int pred [64];
    int fifo [$];
    int path [$];
    logic [63:0] seen;
    int cur;
    int a;
    int b;
    status_t st;
    a = c.vertex_a;
    b = c.vertex_b;
    if (op_t'(c.op) == OP_ADD_VERTEX) begin
      if (nverts >= MaxVertices) queue_expect(mk_res(6'd0, 1'b1, ST_FULL));
      else begin
        nverts++;
        queue_expect(mk_res(6'd0, 1'b1, ST_OK));
      end
      return;
    end
    if (a >= nverts || b >= nverts) begin
      queue_expect(mk_res(6'd0, 1'b1, ST_RANGE));
      return;
    end
    if (op_t'(c.op) == OP_ADD_EDGE) begin
      set_bit(a, b);
      set_bit(b, a);
      queue_expect(mk_res(6'd0, 1'b1, ST_OK));
      return;
    end
    if (op_t'(c.op) == OP_DEL_EDGE) begin
      clr_bit(a, b);
      clr_bit(b, a);
      queue_expect(mk_res(6'd0, 1'b1, ST_OK));
      return;
    end
    foreach (pred[i]) pred[i] = -1;
    seen = '0;
    seen[a] = 1'b1;
    fifo.insert(fifo.size(), a);
    while (fifo.size() > 0) begin
      cur = fifo.pop_front();
      for (int n = 0; n < 64; n++) begin
        if (adj_rows[cur][n] && !seen[n]) begin
          seen[n] = 1'b1;
          pred[n] = cur;
          fifo.insert(fifo.size(), n);
        end
      end
    end
    cur = b;
    while (path.size() < 64) begin
      path.push_front(cur);
      if (pred[cur] < 0) break;
      cur = pred[cur];
    end
    st = (a != b && pred[b] < 0) ? ST_UNREACHABLE : ST_OK;
    foreach (path[i])
      queue_expect(mk_res(6'(path[i]), i == path.size() - 1, st));
  endtask

  task automatic report_mismatch(string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  // driver: bursts with random gaps, optional hold until drained
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
      burst_left <= 0;
    end else begin
      // transaction accepted at this edge
      if (start && !busy) predict_cmd(cmd);
      if (start && busy) begin
        // command still pending, keep it up
      end else if (cmd_q.size() == 0 || gap_left > 0 ||
                   (hold_until_drained && path_q.size() > 0)) begin
        start <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        cmd <= cmd_q[0];
        start <= 1'b1;
        void'(cmd_q.pop_front());
        if (burst_left == 0) begin
          burst_left <= $urandom_range(12, 1);
          gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t want;
    cycles <= cycles + 1;
    if (!rst && done) begin
      if (path_q.size() == 0) report_mismatch("result with nothing expected");
      else begin
        want = path_q.pop_front();
        if (result.path_vertex !== want.path_vertex)
          report_mismatch($sformatf("path_vertex %0d want %0d",
                                    result.path_vertex, want.path_vertex));
        if (result.last !== want.last)
          report_mismatch($sformatf("last %0b want %0b", result.last, want.last));
        if (result.status !== want.status)
          report_mismatch($sformatf("status %0d want %0d", result.status, want.status));
        if (result.vertex_count !== want.vertex_count)
          report_mismatch($sformatf("vertex_count %0d want %0d",
                                    result.vertex_count, want.vertex_count));
        if (result.edge_count !== want.edge_count)
          report_mismatch($sformatf("edge_count %0d want %0d",
                                    result.edge_count, want.edge_count));
      end
    end
    if (cycles > 2000000) begin
      $display("tb_top failed");
      $finish;
    end
  end

  function automatic cmd_t mk_cmd(op_t op, int a, int b);
    cmd_t c;
    c.op = op;
    c.vertex_a = 6'(a);
    c.vertex_b = 6'(b);
    return c;
  endfunction

  task automatic wait_drain();
    while (cmd_q.size() > 0 || start || path_q.size() > 0) @(posedge clk);
  endtask

  initial begin
    int nv;
    int opsel;
    errors = 0;
    cycles = 0;
    hold_until_drained = 1'b0;
    foreach (adj_rows[i]) adj_rows[i] = '0;
    nverts = 0;
    nentries = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: empty graph range errors, small graph, self loop, repeats
    queue_cmd(mk_cmd(OP_QUERY, 0, 0));
    queue_cmd(mk_cmd(OP_ADD_EDGE, 63, 63));
    queue_cmd(mk_cmd(OP_ADD_VERTEX, 63, 63));
    queue_cmd(mk_cmd(OP_ADD_VERTEX, 0, 0));
    queue_cmd(mk_cmd(OP_ADD_VERTEX, 5, 42));
    queue_cmd(mk_cmd(OP_QUERY, 0, 0));
    queue_cmd(mk_cmd(OP_QUERY, 0, 2));
    queue_cmd(mk_cmd(OP_ADD_EDGE, 0, 1));
    queue_cmd(mk_cmd(OP_ADD_EDGE, 1, 0));
    queue_cmd(mk_cmd(OP_ADD_EDGE, 2, 2));
    queue_cmd(mk_cmd(OP_ADD_EDGE, 1, 2));
    queue_cmd(mk_cmd(OP_QUERY, 0, 2));
    queue_cmd(mk_cmd(OP_QUERY, 2, 0));
    queue_cmd(mk_cmd(OP_DEL_EDGE, 0, 2));
    queue_cmd(mk_cmd(OP_DEL_EDGE, 2, 1));
    queue_cmd(mk_cmd(OP_QUERY, 0, 2));
    queue_cmd(mk_cmd(OP_DEL_EDGE, 2, 2));
    queue_cmd(mk_cmd(OP_QUERY, 3, 0));
    queue_cmd(mk_cmd(OP_DEL_EDGE, 0, 63));
    wait_drain();

    // fill the store to full, then a chain across all vertices
    for (int i = 0; i < 62; i++) queue_cmd(mk_cmd(OP_ADD_VERTEX, i, 63 - i));
    queue_cmd(mk_cmd(OP_ADD_VERTEX, 63, 0));
    for (int i = 0; i < 63; i++) queue_cmd(mk_cmd(OP_ADD_EDGE, i, i + 1));
    queue_cmd(mk_cmd(OP_QUERY, 0, 63));
    queue_cmd(mk_cmd(OP_QUERY, 63, 0));
    queue_cmd(mk_cmd(OP_ADD_EDGE, 0, 63));
    queue_cmd(mk_cmd(OP_QUERY, 0, 40));
    wait_drain();

    // random: dense edits among few hot vertices plus queries and vertex adds
    hold_until_drained = 1'b1;
    queue_cmd(mk_cmd(OP_QUERY, 10, 50));
    wait_drain();
    hold_until_drained = 1'b0;
    for (int i = 0; i < 170; i++) begin
      opsel = $urandom_range(9, 0);
      nv = ($urandom_range(3, 0) == 0) ? 64 : 12;
      if (opsel < 4)
        queue_cmd(mk_cmd(OP_ADD_EDGE, $urandom_range(nv - 1, 0),
                         $urandom_range(nv - 1, 0)));
      else if (opsel < 6)
        queue_cmd(mk_cmd(OP_DEL_EDGE, $urandom_range(nv - 1, 0),
                         $urandom_range(nv - 1, 0)));
      else if (opsel < 9)
        queue_cmd(mk_cmd(OP_QUERY, $urandom_range(nv - 1, 0),
                         $urandom_range(nv - 1, 0)));
      else
        queue_cmd(mk_cmd(OP_ADD_VERTEX, $urandom_range(63, 0),
                         $urandom_range(63, 0)));
    end
    wait_drain();
    repeat (300) @(posedge clk);
    if (errors == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule
`default_nettype wire

// ----- files.f -----
+incdir+rtl/core
rtl/core/bsp_pkg.sv
rtl/core/bsp_front.sv
rtl/core/bsp_back.sv
rtl/core/bfs_shortest_path_graph.sv
tb/sv/tb_top.sv
